/* design/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and helpers for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default number of live entries the queue can hold
    localparam int DEPTH_DEF = 64;

    // Priority levels, 1..4 on the ports, 0..3 inside
    localparam int NUM_LVL = 4;
    localparam int LVL_W   = 2;

    // Field widths
    localparam int ID_W     = 22;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 32;

    // Opcodes (s_tuser)
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes (m_tuser)
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_ENQ_WR,
        ST_DEQ_RD,
        ST_RESP
    } spq_state_t;

    // Saturate a 3-bit priority to 1..4 and return the internal level 0..3
    function automatic logic [LVL_W-1:0] prio_to_lvl(input logic [PRIO_W-1:0] p);
        logic [LVL_W-1:0] lvl;
        if (p == 3'd0) begin
            lvl = 2'd0;
        end else if (p > 3'd4) begin
            lvl = 2'd3;
        end else begin
            lvl = LVL_W'(p - 3'd1);
        end
        return lvl;
    endfunction

endpackage

/* design/stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue
// Process queue ordered by priority, first in first out within a level.
// ----------------------------------------------------------------------------
// Usage: each input transaction is an enqueue (s_tuser = 0) or a dequeue
// (s_tuser = 1) and produces exactly one result transaction. Entries live in
// a single-port node memory of DEPTH+4 words as four linked lists, one per
// priority level; each list always ends in a spare tail node, so an enqueue
// writes its id into the current tail and links a freshly allocated spare.
// Nodes come first from a never-used counter, then from a free-slot stack
// memory that dequeues push into. No clearing pass is needed after reset.
// The queue handles one transaction at a time. A dequeue passes ST_DEQ_RD,
// an enqueue ST_ENQ_WR, after ST_ALLOC if it recycles a node, and both then
// ST_RESP; a full or empty case goes straight to ST_RESP. ST_ALLOC and
// ST_DEQ_RD wait on the registered reads of the free-stack and node memories.
// A new input transaction is accepted while a previous result waits on m_.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [21:0] proc_id, [24:22] prio, rest zero
    input  logic [0:0]         s_tuser,   // [0] opcode
    // Result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [21:0] head_id, [24:22] head_prio, rest zero
    output logic [STATUS_W-1:0] m_tuser   // [1:0] status
);

    localparam int NODES = DEPTH + NUM_LVL;
    localparam int NW    = $clog2(NODES);
    localparam int BW    = $clog2(NODES + 1);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(DEPTH);
    localparam int MW    = ID_W + NW;

    // Memories: node store {id, next} and free-slot stack
    logic [MW-1:0] node_mem [NODES];
    logic [NW-1:0] free_mem [DEPTH];

    logic [MW-1:0] node_rd_reg;
    logic [NW-1:0] free_rd_reg;

    // Control state
    spq_state_t state_reg, state_next;
    logic [NW-1:0] head_reg [NUM_LVL];
    logic [NW-1:0] tail_reg [NUM_LVL];
    logic [CW-1:0] cnt_reg  [NUM_LVL];
    logic [CW-1:0] live_reg, live_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [BW-1:0] bump_reg, bump_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // Datapath registers
    logic [ID_W-1:0]     id_reg, id_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [NW-1:0]       alloc_reg, alloc_next;
    logic [NW-1:0]       deq_node_reg, deq_node_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [PRIO_W-1:0]   res_prio_reg, res_prio_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ID_W-1:0]     m_id_reg, m_id_next;
    logic [PRIO_W-1:0]   m_prio_reg, m_prio_next;

    // Sequencer outputs
    logic          in_fire;
    logic          out_free;
    logic          node_re, node_we, free_re, free_we;
    logic [NW-1:0] node_raddr, node_waddr;
    logic [MW-1:0] node_wdata;
    logic [SW-1:0] free_raddr, free_waddr;
    logic          enq_commit, deq_commit;

    // Decoded input and lowest non-empty level
    logic              in_op;
    logic [ID_W-1:0]   in_id;
    logic [LVL_W-1:0]  in_lvl;
    logic [LVL_W-1:0]  sel_lvl;
    logic [NW-1:0]     rd_next_ptr;

    assign in_op   = s_tuser[0];
    assign in_id   = s_tdata[ID_W-1:0];
    assign in_lvl  = prio_to_lvl(s_tdata[ID_W +: PRIO_W]);
    assign in_fire = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_next_ptr = node_rd_reg[NW-1:0];

    always_comb begin
        if (cnt_reg[0] != '0) begin
            sel_lvl = 2'd0;
        end else if (cnt_reg[1] != '0) begin
            sel_lvl = 2'd1;
        end else if (cnt_reg[2] != '0) begin
            sel_lvl = 2'd2;
        end else begin
            sel_lvl = 2'd3;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_op == OP_ENQ) begin
                        if (live_reg == CW'(DEPTH)) begin
                            state_next = ST_RESP;
                        end else if (bump_reg != BW'(NODES)) begin
                            state_next = ST_ENQ_WR;
                        end else begin
                            state_next = ST_ALLOC;
                        end
                    end else begin
                        if (live_reg == '0) begin
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_DEQ_RD;
                        end
                    end
                end
            end
            ST_ALLOC:  state_next = ST_ENQ_WR;
            ST_ENQ_WR: state_next = ST_RESP;
            ST_DEQ_RD: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, memory ports, commits
    always_comb begin
        s_tready   = 1'b0;
        node_re    = 1'b0;
        node_we    = 1'b0;
        free_re    = 1'b0;
        free_we    = 1'b0;
        node_raddr = head_reg[sel_lvl];
        node_waddr = tail_reg[lvl_reg];
        node_wdata = {id_reg, alloc_reg};
        free_raddr = SW'(sp_reg - CW'(1));
        free_waddr = sp_reg[SW-1:0];
        enq_commit = 1'b0;
        deq_commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_op == OP_ENQ) begin
                        free_re = (live_reg != CW'(DEPTH)) && (bump_reg == BW'(NODES));
                    end else begin
                        node_re = (live_reg != '0);
                    end
                end
            end
            ST_ENQ_WR: begin
                node_we    = 1'b1;
                enq_commit = 1'b1;
            end
            ST_DEQ_RD: begin
                free_we    = 1'b1;
                deq_commit = 1'b1;
            end
            default: ;
        endcase
    end

    // Datapath and counter next values
    always_comb begin
        live_next       = live_reg;
        sp_next         = sp_reg;
        bump_next       = bump_reg;
        id_next         = id_reg;
        lvl_next        = lvl_reg;
        alloc_next      = alloc_reg;
        deq_node_next   = deq_node_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_prio_next   = res_prio_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_prio_next     = m_prio_reg;

        // Output register drains independently of the sequencer
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    id_next         = in_id;
                    res_status_next = STAT_OK;
                    res_id_next     = '0;
                    res_prio_next   = '0;
                    if (in_op == OP_ENQ) begin
                        lvl_next = in_lvl;
                        if (live_reg == CW'(DEPTH)) begin
                            res_status_next = STAT_FULL;
                        end else if (bump_reg != BW'(NODES)) begin
                            alloc_next = bump_reg[NW-1:0];
                            bump_next  = bump_reg + BW'(1);
                        end else begin
                            sp_next = sp_reg - CW'(1);
                        end
                    end else begin
                        lvl_next      = sel_lvl;
                        deq_node_next = head_reg[sel_lvl];
                        if (live_reg == '0) begin
                            res_status_next = STAT_EMPTY;
                        end
                    end
                end
            end
            ST_ALLOC: begin
                alloc_next = free_rd_reg;
            end
            ST_ENQ_WR: begin
                live_next = live_reg + CW'(1);
            end
            ST_DEQ_RD: begin
                live_next     = live_reg - CW'(1);
                sp_next       = sp_reg + CW'(1);
                res_id_next   = node_rd_reg[MW-1:NW];
                res_prio_next = PRIO_W'(lvl_reg) + PRIO_W'(1);
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_id_next     = res_id_reg;
                    m_prio_next   = res_prio_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            live_reg     <= '0;
            sp_reg       <= '0;
            bump_reg     <= BW'(NUM_LVL);
            m_tvalid_reg <= 1'b0;
            for (int l = 0; l < NUM_LVL; l++) begin
                head_reg[l] <= NW'(l);
                tail_reg[l] <= NW'(l);
                cnt_reg[l]  <= '0;
            end
        end else begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            sp_reg       <= sp_next;
            bump_reg     <= bump_next;
            m_tvalid_reg <= m_tvalid_next;
            // Enqueue: spare node becomes the new tail of its level
            if (enq_commit) begin
                tail_reg[lvl_reg] <= alloc_reg;
                cnt_reg[lvl_reg]  <= cnt_reg[lvl_reg] + CW'(1);
            end
            // Dequeue: head advances along its link
            if (deq_commit) begin
                head_reg[lvl_reg] <= rd_next_ptr;
                cnt_reg[lvl_reg]  <= cnt_reg[lvl_reg] - CW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        lvl_reg        <= lvl_next;
        alloc_reg      <= alloc_next;
        deq_node_reg   <= deq_node_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_prio_reg   <= res_prio_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_prio_reg     <= m_prio_next;
    end

    // Node memory, registered read
    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            node_rd_reg <= node_mem[node_raddr];
        end
    end

    // Free-slot stack memory, registered read
    always_ff @(posedge aclk) begin
        if (free_we) begin
            free_mem[free_waddr] <= deq_node_reg;
        end
        if (free_re) begin
            free_rd_reg <= free_mem[free_raddr];
        end
    end

    // Result channel
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {(TDATA_W - ID_W - PRIO_W)'(0), m_prio_reg, m_id_reg};

    // Checks
    logic [CW+1:0] cnt_sum;
    assign cnt_sum = (CW+2)'(cnt_reg[0]) + (CW+2)'(cnt_reg[1])
                   + (CW+2)'(cnt_reg[2]) + (CW+2)'(cnt_reg[3]);

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(DEPTH))
        else $error("live count exceeds depth");

    a_level_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_sum == (CW+2)'(live_reg))
        else $error("level counts disagree with live count");

    a_node_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |->
            ((BW+1)'(bump_reg) == (BW+1)'(sp_reg) + (BW+1)'(live_reg) + (BW+1)'(NUM_LVL)))
        else $error("node accounting lost a slot");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg != STAT_OK)) |->
            (m_id_reg == '0 && m_prio_reg == '0))
        else $error("failed transaction carries an entry");

endmodule

/* test/stable_priority_queue_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_test
// Self-checking bench for the stable priority queue. Enqueue and dequeue
// transactions go in on the s_ channel. A behavioral queue model predicts
// every result, and each result on the m_ channel is compared field by field
// with the oldest prediction. Covered: empty and full cases, priority
// saturation, order within a level, random fill and drain sweeps, a long
// receiver stall, and a last stretch with no idling.
// ----------------------------------------------------------------------------
module stable_priority_queue_test;
    import spq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 20;

    // One queued process entry, level is priority minus one
    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic [ID_W-1:0]  id;
    } proc_entry_t;

    // One predicted result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [PRIO_W-1:0]   prio;
    } sched_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic [0:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    // Model of queue contents, head at index 0
    proc_entry_t   ready_list[$];
    // Results still owed by the block, oldest first
    sched_result_t owed_results[$];

    int  err_count;
    int  result_seq;
    int  cycle_count;
    bit  src_idle_on;
    bit  sink_idle_on;
    int  sink_hold_cycles;

    stable_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Apply one operation to the queue model and return the result it owes
    function automatic sched_result_t schedule_op(input logic op,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [PRIO_W-1:0] prio);
        sched_result_t res;
        proc_entry_t   ent;
        int            pos;
        res = '0;
        res.status = STAT_OK;
        if (op == OP_ENQ) begin
            if (ready_list.size() >= QDEPTH) begin
                res.status = STAT_FULL;
            end else begin
                // saturate to 1..4
                if (prio == 3'd0) begin
                    ent.lvl = 2'd0;
                end else if (prio >= 3'd4) begin
                    ent.lvl = 2'd3;
                end else begin
                    ent.lvl = prio[LVL_W-1:0] - 2'd1;
                end
                ent.id = id;
                // goes behind every entry of the same or a better level
                pos = ready_list.size();
                while (pos > 0 && ent.lvl < ready_list[pos-1].lvl) begin
                    pos--;
                end
                ready_list.insert(pos, ent);
            end
        end else begin
            if (ready_list.size() == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                ent = ready_list.pop_front();
                res.id   = ent.id;
                res.prio = PRIO_W'(ent.lvl) + 3'd1;
            end
        end
        return res;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR result %0d: %s got 0x%0h expected 0x%0h",
                 result_seq, what, got, want);
        err_count++;
    endtask

    // Send one transaction and record what it should produce
    task automatic send_op(input logic op, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio);
        @(negedge aclk);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(TDATA_W-ID_W-PRIO_W){1'b0}}, prio, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        owed_results.push_back(schedule_op(op, id, prio));
    endtask

    // Mostly legal priorities, sometimes any 3-bit value
    function automatic logic [PRIO_W-1:0] pick_prio();
        if ($urandom_range(0, 7) == 0) begin
            return PRIO_W'($urandom_range(0, 7));
        end
        return PRIO_W'($urandom_range(1, 4));
    endfunction

    // Random transaction, enqueue with the given percent chance
    task automatic send_random(input int enq_pct);
        logic op;
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_op(op, ID_W'($urandom), pick_prio());
    endtask

    // Drop valid and hold off until every owed result has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
    endtask

    // Dequeue on an empty queue, with junk in the ignored fields
    task automatic test_empty_dequeue();
        send_op(OP_DEQ, 22'h3FFFFF, 3'd7);
        send_op(OP_DEQ, 22'h000000, 3'd0);
        wait_drained();
    endtask

    // All levels, saturation both ways, id extremes, FIFO order within a level
    task automatic test_priority_levels();
        send_op(OP_ENQ, 22'h000000, 3'd4);
        send_op(OP_ENQ, 22'h3FFFFF, 3'd3);
        send_op(OP_ENQ, 22'h155555, 3'd2);
        send_op(OP_ENQ, 22'h2AAAAA, 3'd1);
        send_op(OP_ENQ, 22'h000001, 3'd7);
        send_op(OP_ENQ, 22'h000002, 3'd0);
        send_op(OP_ENQ, 22'h000003, 3'd5);
        send_op(OP_ENQ, 22'h000004, 3'd6);
        repeat (9) send_op(OP_DEQ, 22'h2AAAAA, 3'd2);
        wait_drained();
    endtask

    // Fill past full, then drain past empty
    task automatic test_fill_and_drain();
        repeat (QDEPTH + 2) send_random(100);
        repeat (QDEPTH + 2) send_random(0);
        wait_drained();
    endtask

    // Random mix that sweeps the fill level between the extremes
    task automatic test_random_sweep();
        int target;
        int enq_pct;
        target = 0;
        for (int n = 0; n < 400; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        target = 0;
                    end
                    1: begin
                        target = QDEPTH + 4;
                    end
                    default: begin
                        target = $urandom_range(1, QDEPTH - 1);
                    end
                endcase
            end
            enq_pct = (ready_list.size() < target) ? 80 : 20;
            send_random(enq_pct);
        end
        wait_drained();
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering
    task automatic test_long_stall();
        sink_hold_cycles = 300;
        repeat (24) send_random(60);
        wait_drained();
    endtask

    // Back to back traffic, no idling on either side
    task automatic test_streaming();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (110) send_random(50);
        wait_drained();
    endtask

    // Receiver: random idle bursts and the occasional long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles - 1) @(negedge aclk);
                sink_hold_cycles = 0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker
    initial begin
        sched_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected transaction, status", m_tuser, 0);
                end else begin
                    want = owed_results.pop_front();
                    if (m_tuser !== want.status) begin
                        report_mismatch("status", m_tuser, want.status);
                    end
                    if (m_tdata[ID_W-1:0] !== want.id) begin
                        report_mismatch("head_id", m_tdata[ID_W-1:0], want.id);
                    end
                    if (m_tdata[ID_W+PRIO_W-1:ID_W] !== want.prio) begin
                        report_mismatch("head_prio", m_tdata[ID_W+PRIO_W-1:ID_W], want.prio);
                    end
                    if (m_tdata[TDATA_W-1:ID_W+PRIO_W] !== '0) begin
                        report_mismatch("tdata pad", m_tdata[TDATA_W-1:ID_W+PRIO_W], 0);
                    end
                end
                result_seq++;
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("stable_priority_queue verification failed");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = OP_ENQ;
        err_count        = 0;
        result_seq       = 0;
        src_idle_on      = 1'b0;
        sink_idle_on     = 1'b0;
        sink_hold_cycles = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_dequeue();
        test_priority_levels();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_fill_and_drain();
        test_random_sweep();
        test_long_stall();
        test_streaming();

        repeat (SETTLE_CYC) @(posedge aclk);
        if (err_count == 0 && owed_results.size() == 0) begin
            $display("stable_priority_queue verification clean");
        end else begin
            $display("stable_priority_queue verification failed");
        end
        $finish;
    end

endmodule
